FILE: design/sws_pkg.sv
// shared constants, codes and control types for the sliding window sender
package sws_pkg;

  localparam int SEQ_MAX      = 16;
  localparam int SEQ_W        = $clog2(SEQ_MAX);
  localparam int SPACE_W      = $clog2(SEQ_MAX + 1);
  localparam int SUM_W        = SPACE_W + 1;
  localparam int WIN_W        = 4;
  localparam int PAYLOAD_BITS = 32;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int DUP_W        = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;

  localparam logic [DUP_W-1:0] DUP_TRIGGER = 3'd3;
  localparam logic [DUP_W-1:0] DUP_LIMIT   = 3'd7;

  localparam logic [SPACE_W-1:0] SPACE_MIN = SPACE_W'(2);
  localparam logic [SPACE_W-1:0] SPACE_TOP = SPACE_W'(SEQ_MAX);

  localparam logic [WIN_W-1:0]   WINDOW_RESET = 4'd4;
  localparam logic [SPACE_W-1:0] SPACE_RESET  = SPACE_W'(8);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_SPACE   = 1'd1;

  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_SENT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SLID    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CK  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

  typedef struct packed {
    logic step;  // execute the accepted transaction
    logic norm;  // pull base and next positions back into the space
  } sws_cmd_t;

  typedef struct packed {
    logic norm_ok;
  } sws_sts_t;

endpackage

FILE: design/sws_in_if.sv
// input channel: one packet event per transaction
interface sws_in_if;
  logic                               valid;
  logic                               ready;
  logic [sws_pkg::MODE_W-1:0]         mode;
  logic [sws_pkg::PAYLOAD_BITS-1:0]   payload;
  logic [sws_pkg::SEQ_W-1:0]          ack_num;
  logic                               checksum_ok;
  logic [sws_pkg::SEQ_W-1:0]          expired_seq;

  modport source (output valid, mode, payload, ack_num, checksum_ok, expired_seq,
                  input ready);
  modport sink (input valid, mode, payload, ack_num, checksum_ok, expired_seq,
                output ready);
endinterface

FILE: design/sws_out_if.sv
// result channel: transmit, timer and status for each event
interface sws_out_if;
  logic                               valid;
  logic                               ready;
  logic [sws_pkg::STATUS_W-1:0]       status;
  logic                               tx_valid;
  logic [sws_pkg::SEQ_W-1:0]          tx_seq;
  logic [sws_pkg::PAYLOAD_BITS-1:0]   tx_payload;
  logic                               timer_stop;
  logic [sws_pkg::SEQ_W-1:0]          stop_seq;
  logic                               timer_start;
  logic [sws_pkg::SEQ_W-1:0]          start_seq;
  logic                               window_full;

  modport source (output valid, status, tx_valid, tx_seq, tx_payload, timer_stop,
                  stop_seq, timer_start, start_seq, window_full,
                  input ready);
  modport sink (input valid, status, tx_valid, tx_seq, tx_payload, timer_stop,
                stop_seq, timer_start, start_seq, window_full,
                output ready);
endinterface

FILE: design/sws_ctrl.sv
// controller: accept gating, position reduction sequencing, result register valid
module sws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sws_pkg::sws_sts_t sts,
  output sws_pkg::sws_cmd_t cmd
);

  localparam logic ST_READY = 1'b0;
  localparam logic ST_NORM  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready  = (state_r == ST_READY) && sts.norm_ok && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.step      = accept;
    cmd.norm      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = accept || (out_valid_r && !out_ready);
    unique case (state_r)
      ST_READY: begin
        if (!sts.norm_ok) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (sts.norm_ok) begin
          state_nxt = ST_READY;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/sws_datapath.sv
// datapath: window state, payload buffer, modular arithmetic and result registers
module sws_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sws_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  sws_pkg::sws_cmd_t                   cmd,
  output sws_pkg::sws_sts_t                   sts,
  input  logic [sws_pkg::MODE_W-1:0]          in_mode,
  input  logic [sws_pkg::PAYLOAD_BITS-1:0]    in_payload,
  input  logic [sws_pkg::SEQ_W-1:0]           in_ack_num,
  input  logic                                in_checksum_ok,
  input  logic [sws_pkg::SEQ_W-1:0]           in_expired_seq,
  output logic [sws_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_tx_valid,
  output logic [sws_pkg::SEQ_W-1:0]           out_tx_seq,
  output logic [sws_pkg::PAYLOAD_BITS-1:0]    out_tx_payload,
  output logic                                out_timer_stop,
  output logic [sws_pkg::SEQ_W-1:0]           out_stop_seq,
  output logic                                out_timer_start,
  output logic [sws_pkg::SEQ_W-1:0]           out_start_seq,
  output logic                                out_window_full
);

  localparam int SEQ_W   = sws_pkg::SEQ_W;
  localparam int SPACE_W = sws_pkg::SPACE_W;
  localparam int SUM_W   = sws_pkg::SUM_W;
  localparam int WIN_W   = sws_pkg::WIN_W;
  localparam int PW      = sws_pkg::PAYLOAD_BITS;
  localparam int DUP_W   = sws_pkg::DUP_W;

  logic [PW-1:0] slot_mem [sws_pkg::SEQ_MAX];

  logic [WIN_W-1:0]   window_size_r;
  logic [SPACE_W-1:0] seq_space_r;
  logic [SEQ_W-1:0]   base_r, base_nxt;
  logic [SEQ_W-1:0]   next_r, next_nxt;
  logic [WIN_W-1:0]   outst_r, outst_nxt;
  logic [DUP_W-1:0]   dup_r, dup_nxt;

  logic [sws_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                         txv_r, txv_nxt;
  logic [SEQ_W-1:0]             txs_r, txs_nxt;
  logic [PW-1:0]                txp_r;
  logic                         tstop_r, tstop_nxt;
  logic [SEQ_W-1:0]             ssq_r, ssq_nxt;
  logic                         tstart_r, tstart_nxt;
  logic [SEQ_W-1:0]             stsq_r, stsq_nxt;
  logic                         full_r, full_nxt;
  logic                         wr_en, resend;

  logic [SPACE_W-1:0] s_eff;
  logic [WIN_W-1:0]   w_base;
  logic [WIN_W-1:0]   w_eff;
  logic [SPACE_W-1:0] s_less1;

  logic [SUM_W-1:0] s_ext, base_ext, next_ext, ack_ext;
  logic [SUM_W-1:0] off_sum, off_mod;
  logic [SUM_W-1:0] slide_sum, slide_mod;
  logic [SUM_W-1:0] prev_sum, prev_mod;
  logic [SUM_W-1:0] inc_sum;
  logic [SEQ_W-1:0] off;
  logic [DUP_W-1:0] dup_inc;

  // effective space and window after clamping
  always_comb begin
    if (seq_space_r < sws_pkg::SPACE_MIN) begin
      s_eff = sws_pkg::SPACE_MIN;
    end else if (seq_space_r > sws_pkg::SPACE_TOP) begin
      s_eff = sws_pkg::SPACE_TOP;
    end else begin
      s_eff = seq_space_r;
    end
    s_less1 = s_eff - SPACE_W'(1);
    w_base  = (window_size_r == '0) ? WIN_W'(1) : window_size_r;
    if (SPACE_W'(w_base) > s_less1) begin
      w_eff = s_less1[WIN_W-1:0];
    end else begin
      w_eff = w_base;
    end
  end

  assign sts.norm_ok = (SPACE_W'(base_r) < s_eff) && (SPACE_W'(next_r) < s_eff);

  // modular helpers: each sum stays below twice the space
  always_comb begin
    s_ext     = SUM_W'(s_eff);
    base_ext  = SUM_W'(base_r);
    next_ext  = SUM_W'(next_r);
    ack_ext   = SUM_W'(in_ack_num);
    off_sum   = ack_ext + s_ext - base_ext;
    off_mod   = (off_sum >= s_ext) ? off_sum - s_ext : off_sum;
    off       = off_mod[SEQ_W-1:0];
    slide_sum = base_ext + off_mod + SUM_W'(1);
    slide_mod = (slide_sum >= s_ext) ? slide_sum - s_ext : slide_sum;
    prev_sum  = base_ext + s_ext - SUM_W'(1);
    prev_mod  = (prev_sum >= s_ext) ? prev_sum - s_ext : prev_sum;
    inc_sum   = next_ext + SUM_W'(1);
    dup_inc   = (dup_r < sws_pkg::DUP_LIMIT) ? dup_r + DUP_W'(1) : dup_r;
  end

  always_comb begin
    base_nxt   = base_r;
    next_nxt   = next_r;
    outst_nxt  = outst_r;
    dup_nxt    = dup_r;
    status_nxt = sws_pkg::ST_IGNORED;
    txv_nxt    = 1'b0;
    txs_nxt    = '0;
    tstop_nxt  = 1'b0;
    ssq_nxt    = '0;
    tstart_nxt = 1'b0;
    stsq_nxt   = '0;
    wr_en      = 1'b0;
    resend     = 1'b0;
    unique case (in_mode)
      sws_pkg::MODE_SEND: begin
        if (outst_r >= w_eff) begin
          status_nxt = sws_pkg::ST_REFUSED;
        end else begin
          wr_en      = 1'b1;
          status_nxt = sws_pkg::ST_SENT;
          txv_nxt    = 1'b1;
          txs_nxt    = next_r;
          if (outst_r == '0) begin
            tstart_nxt = 1'b1;
            stsq_nxt   = next_r;
          end
          next_nxt  = (inc_sum == s_ext) ? '0 : inc_sum[SEQ_W-1:0];
          outst_nxt = outst_r + WIN_W'(1);
        end
      end
      sws_pkg::MODE_ACK: begin
        if (!in_checksum_ok) begin
          status_nxt = sws_pkg::ST_BAD_CK;
        end else if (ack_ext < s_ext) begin
          if (WIN_W'(off) < outst_r) begin
            status_nxt = sws_pkg::ST_SLID;
            tstop_nxt  = 1'b1;
            ssq_nxt    = base_r;
            base_nxt   = slide_mod[SEQ_W-1:0];
            outst_nxt  = outst_r - WIN_W'(off) - WIN_W'(1);
            dup_nxt    = '0;
            if (outst_nxt != '0) begin
              tstart_nxt = 1'b1;
              stsq_nxt   = base_nxt;
            end
          end else if (ack_ext == prev_mod) begin
            status_nxt = sws_pkg::ST_DUP;
            dup_nxt    = dup_inc;
            // fast retransmit on the third duplicate
            if (dup_inc == sws_pkg::DUP_TRIGGER && outst_r != '0) begin
              txv_nxt = 1'b1;
              txs_nxt = base_r;
              resend  = 1'b1;
              dup_nxt = '0;
            end
          end
        end
      end
      sws_pkg::MODE_TIMEOUT: begin
        if (outst_r != '0) begin
          tstop_nxt  = 1'b1;
          ssq_nxt    = in_expired_seq;
          tstart_nxt = 1'b1;
          stsq_nxt   = in_expired_seq;
          txv_nxt    = 1'b1;
          txs_nxt    = base_r;
          resend     = 1'b1;
        end
      end
      default: begin
        status_nxt = sws_pkg::ST_IGNORED;
      end
    endcase
    full_nxt = (outst_nxt >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= sws_pkg::WINDOW_RESET;
      seq_space_r   <= sws_pkg::SPACE_RESET;
      base_r        <= '0;
      next_r        <= '0;
      outst_r       <= '0;
      dup_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sws_pkg::CFG_WINDOW_SIZE: window_size_r <= cfg_data[WIN_W-1:0];
          sws_pkg::CFG_SEQ_SPACE:   seq_space_r   <= cfg_data[SPACE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        base_r  <= base_nxt;
        next_r  <= next_nxt;
        outst_r <= outst_nxt;
        dup_r   <= dup_nxt;
      end else if (cmd.norm) begin
        // one subtraction of the space per cycle after a space change
        if (SPACE_W'(base_r) >= s_eff) begin
          base_r <= SEQ_W'(SPACE_W'(base_r) - s_eff);
        end
        if (SPACE_W'(next_r) >= s_eff) begin
          next_r <= SEQ_W'(SPACE_W'(next_r) - s_eff);
        end
      end
    end
  end

  // payload buffer with registered read into the result register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (wr_en) begin
        slot_mem[next_r] <= in_payload;
        txp_r            <= in_payload;
      end else if (resend) begin
        txp_r <= slot_mem[base_r];
      end else begin
        txp_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      status_r <= status_nxt;
      txv_r    <= txv_nxt;
      txs_r    <= txs_nxt;
      tstop_r  <= tstop_nxt;
      ssq_r    <= ssq_nxt;
      tstart_r <= tstart_nxt;
      stsq_r   <= stsq_nxt;
      full_r   <= full_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_tx_valid    = txv_r;
  assign out_tx_seq      = txs_r;
  assign out_tx_payload  = txp_r;
  assign out_timer_stop  = tstop_r;
  assign out_stop_seq    = ssq_r;
  assign out_timer_start = tstart_r;
  assign out_start_seq   = stsq_r;
  assign out_window_full = full_r;

endmodule

FILE: design/sliding_window_sender.sv
// Go-back-N sliding window sender with fast retransmit on the third duplicate
// acknowledgement. Each transaction on in_ch (send, acknowledgement or timer
// expiry) yields exactly one transaction on out_ch, registered and presented the
// cycle after acceptance; a new event is taken every cycle while the result
// register is empty or being drained, so the steady rate is one event per cycle.
// After seq_space is reprogrammed to a value that leaves the base or next
// position outside the new space, the block stops accepting while the
// controller moves to its reduction state, pulls those positions back (one
// subtraction of the space per cycle) and returns to its ready state.
// Configuration takes effect on the next event and must only be written while
// no result is pending.
module sliding_window_sender (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sws_pkg::CFG_DATA_W-1:0]    cfg_data,
  sws_in_if.sink                            in_ch,
  sws_out_if.source                         out_ch
);

  sws_pkg::sws_cmd_t cmd;
  sws_pkg::sws_sts_t sts;

  sws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sws_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_ch.mode),
    .in_payload      (in_ch.payload),
    .in_ack_num      (in_ch.ack_num),
    .in_checksum_ok  (in_ch.checksum_ok),
    .in_expired_seq  (in_ch.expired_seq),
    .out_status      (out_ch.status),
    .out_tx_valid    (out_ch.tx_valid),
    .out_tx_seq      (out_ch.tx_seq),
    .out_tx_payload  (out_ch.tx_payload),
    .out_timer_stop  (out_ch.timer_stop),
    .out_stop_seq    (out_ch.stop_seq),
    .out_timer_start (out_ch.timer_start),
    .out_start_seq   (out_ch.start_seq),
    .out_window_full (out_ch.window_full)
  );

endmodule

FILE: verif/tb_sliding_window_sender.sv
// self-checking testbench for the go-back-n sliding window sender
module tb_sliding_window_sender;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_W        = sws_pkg::SEQ_W;
  localparam int MODE_W       = sws_pkg::MODE_W;
  localparam int CFG_DATA_W   = sws_pkg::CFG_DATA_W;
  localparam int RESULT_SLOTS = 8;

  localparam logic [sws_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int STALL_LIMIT     = 2000;

  typedef struct packed {
    logic [sws_pkg::MODE_W-1:0]       mode;
    logic [sws_pkg::PAYLOAD_BITS-1:0] payload;
    logic [sws_pkg::SEQ_W-1:0]        ack_num;
    logic                             checksum_ok;
    logic [sws_pkg::SEQ_W-1:0]        expired_seq;
  } sws_event_t;

  typedef struct packed {
    logic [sws_pkg::STATUS_W-1:0]     status;
    logic                             tx_valid;
    logic [sws_pkg::SEQ_W-1:0]        tx_seq;
    logic [sws_pkg::PAYLOAD_BITS-1:0] tx_payload;
    logic                             timer_stop;
    logic [sws_pkg::SEQ_W-1:0]        stop_seq;
    logic                             timer_start;
    logic [sws_pkg::SEQ_W-1:0]        start_seq;
    logic                             window_full;
  } sws_result_t;

  class sender_scoreboard;
    int unsigned                      win_reg;
    int unsigned                      space_reg;
    int unsigned                      base_pos;
    int unsigned                      next_pos;
    int unsigned                      in_flight;
    int unsigned                      dup_acks;
    logic [sws_pkg::PAYLOAD_BITS-1:0] slot_data [sws_pkg::SEQ_MAX];
    bit                               slot_filled [sws_pkg::SEQ_MAX];
    sws_result_t                      awaited [RESULT_SLOTS];
    int unsigned                      head_idx;
    int unsigned                      tail_idx;
    int unsigned                      pending;
    int unsigned                      failures;

    function new();
      win_reg   = sws_pkg::WINDOW_RESET;
      space_reg = sws_pkg::SPACE_RESET;
      base_pos  = 0;
      next_pos  = 0;
      in_flight = 0;
      dup_acks  = 0;
      head_idx  = 0;
      tail_idx  = 0;
      pending   = 0;
      failures  = 0;
      foreach (slot_filled[i]) slot_filled[i] = 1'b0;
    endfunction

    function void write_reg(logic [sws_pkg::CFG_IDX_W-1:0] idx,
                            logic [sws_pkg::CFG_DATA_W-1:0] data);
      if (idx == sws_pkg::CFG_WINDOW_SIZE) win_reg = data[sws_pkg::WIN_W-1:0];
      else if (idx == sws_pkg::CFG_SEQ_SPACE) space_reg = data;
    endfunction

    function int unsigned space_now();
      int unsigned s;
      s = space_reg;
      if (s < sws_pkg::SPACE_MIN) s = sws_pkg::SPACE_MIN;
      if (s > sws_pkg::SPACE_TOP) s = sws_pkg::SPACE_TOP;
      return s;
    endfunction

    function int unsigned window_now(int unsigned s);
      int unsigned w;
      w = win_reg;
      if (w == 0) w = 1;
      if (w > s - 1) w = s - 1;
      return w;
    endfunction

    // true when the event would retransmit a slot that no send has filled
    function bit hits_empty_slot(sws_event_t ev);
      int unsigned s, b, off, d;
      s = space_now();
      b = base_pos % s;
      if (in_flight == 0) return 1'b0;
      if (ev.mode == sws_pkg::MODE_TIMEOUT) return !slot_filled[b];
      if (ev.mode != sws_pkg::MODE_ACK || !ev.checksum_ok || ev.ack_num >= s) return 1'b0;
      off = (ev.ack_num + s - b) % s;
      if (off < in_flight || ev.ack_num != (b + s - 1) % s) return 1'b0;
      d = (dup_acks < sws_pkg::DUP_LIMIT) ? dup_acks + 1 : dup_acks;
      return (d == sws_pkg::DUP_TRIGGER) && !slot_filled[b];
    endfunction

    function void note_event(sws_event_t ev);
      int unsigned s, w, off;
      sws_result_t r;
      s = space_now();
      w = window_now(s);
      base_pos = base_pos % s;
      next_pos = next_pos % s;
      r = '0;
      r.status = sws_pkg::ST_IGNORED;
      case (ev.mode)
        sws_pkg::MODE_SEND: begin
          if (in_flight >= w) begin
            r.status = sws_pkg::ST_REFUSED;
          end else begin
            slot_data[next_pos]   = ev.payload;
            slot_filled[next_pos] = 1'b1;
            r.status     = sws_pkg::ST_SENT;
            r.tx_valid   = 1'b1;
            r.tx_seq     = SEQ_W'(next_pos);
            r.tx_payload = ev.payload;
            if (in_flight == 0) begin
              r.timer_start = 1'b1;
              r.start_seq   = SEQ_W'(next_pos);
            end
            next_pos  = (next_pos + 1) % s;
            in_flight = in_flight + 1;
          end
        end
        sws_pkg::MODE_ACK: begin
          if (!ev.checksum_ok) begin
            r.status = sws_pkg::ST_BAD_CK;
          end else if (ev.ack_num < s) begin
            off = (ev.ack_num + s - base_pos) % s;
            if (off < in_flight) begin
              r.status     = sws_pkg::ST_SLID;
              r.timer_stop = 1'b1;
              r.stop_seq   = SEQ_W'(base_pos);
              base_pos  = (base_pos + off + 1) % s;
              in_flight = in_flight - (off + 1);
              dup_acks  = 0;
              if (in_flight > 0) begin
                r.timer_start = 1'b1;
                r.start_seq   = SEQ_W'(base_pos);
              end
            end else if (ev.ack_num == (base_pos + s - 1) % s) begin
              r.status = sws_pkg::ST_DUP;
              if (dup_acks < sws_pkg::DUP_LIMIT) dup_acks = dup_acks + 1;
              // fast retransmit only with something in flight
              if (dup_acks == sws_pkg::DUP_TRIGGER && in_flight > 0) begin
                r.tx_valid   = 1'b1;
                r.tx_seq     = SEQ_W'(base_pos);
                r.tx_payload = slot_data[base_pos];
                dup_acks     = 0;
              end
            end
          end
        end
        sws_pkg::MODE_TIMEOUT: begin
          if (in_flight > 0) begin
            r.timer_stop  = 1'b1;
            r.stop_seq    = ev.expired_seq;
            r.timer_start = 1'b1;
            r.start_seq   = ev.expired_seq;
            r.tx_valid    = 1'b1;
            r.tx_seq      = SEQ_W'(base_pos);
            r.tx_payload  = slot_data[base_pos];
          end
        end
        default: ;
      endcase
      r.window_full = (in_flight >= w);
      if (pending == RESULT_SLOTS) begin
        failures++;
        if (failures <= 10) $display("too many results outstanding at %0t", $realtime);
      end else begin
        awaited[tail_idx] = r;
        tail_idx = (tail_idx + 1) % RESULT_SLOTS;
        pending++;
      end
    endfunction

    function string show(sws_result_t r);
      return $sformatf("st=%0d tx=%0b/%0d/%h stop=%0b/%0d start=%0b/%0d full=%0b",
                       r.status, r.tx_valid, r.tx_seq, r.tx_payload, r.timer_stop,
                       r.stop_seq, r.timer_start, r.start_seq, r.window_full);
    endfunction

    function void check_result(sws_result_t got);
      sws_result_t want;
      string diffs;
      if (pending == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want     = awaited[head_idx];
      head_idx = (head_idx + 1) % RESULT_SLOTS;
      pending--;
      diffs = "";
      if (got.status !== want.status)           diffs = {diffs, " status"};
      if (got.tx_valid !== want.tx_valid)       diffs = {diffs, " tx_valid"};
      if (got.tx_seq !== want.tx_seq)           diffs = {diffs, " tx_seq"};
      if (got.tx_payload !== want.tx_payload)   diffs = {diffs, " tx_payload"};
      if (got.timer_stop !== want.timer_stop)   diffs = {diffs, " timer_stop"};
      if (got.stop_seq !== want.stop_seq)       diffs = {diffs, " stop_seq"};
      if (got.timer_start !== want.timer_start) diffs = {diffs, " timer_start"};
      if (got.start_seq !== want.start_seq)     diffs = {diffs, " start_seq"};
      if (got.window_full !== want.window_full) diffs = {diffs, " window_full"};
      if (diffs != "") begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch in%s at %0t", diffs, $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sws_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sws_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                    src_idle_pct = 0;
  int unsigned                    sink_stall_pct = 0;
  int unsigned                    quiet_cycles = 0;
  sender_scoreboard               sb;

  sws_in_if  in_ch();
  sws_out_if out_ch();

  sliding_window_sender dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    sws_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.tx_valid    = out_ch.tx_valid;
      got.tx_seq      = out_ch.tx_seq;
      got.tx_payload  = out_ch.tx_payload;
      got.timer_stop  = out_ch.timer_stop;
      got.stop_seq    = out_ch.stop_seq;
      got.timer_start = out_ch.timer_start;
      got.start_seq   = out_ch.start_seq;
      got.window_full = out_ch.window_full;
      sb.check_result(got);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic sws_event_t mk_event(logic [sws_pkg::MODE_W-1:0] mode,
                                          logic [sws_pkg::PAYLOAD_BITS-1:0] payload,
                                          logic [sws_pkg::SEQ_W-1:0] ack, logic ck,
                                          logic [sws_pkg::SEQ_W-1:0] expired);
    sws_event_t ev;
    ev.mode        = mode;
    ev.payload     = payload;
    ev.ack_num     = ack;
    ev.checksum_ok = ck;
    ev.expired_seq = expired;
    return ev;
  endfunction

  // mostly protocol-shaped events against the current window, some raw noise
  function automatic sws_event_t random_event();
    sws_event_t  ev;
    int unsigned s, b, pick;
    s = sb.space_now();
    b = sb.base_pos % s;
    ev = mk_event(sws_pkg::MODE_SEND, $urandom, SEQ_W'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), SEQ_W'($urandom_range(0, 15)));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      ev.mode = sws_pkg::MODE_SEND;
    end else if (pick < 60) begin
      ev.mode        = sws_pkg::MODE_ACK;
      ev.checksum_ok = 1'b1;
      if (sb.in_flight > 0) ev.ack_num = SEQ_W'((b + $urandom_range(0, sb.in_flight - 1)) % s);
      else ev.ack_num = SEQ_W'($urandom_range(0, s - 1));
    end else if (pick < 72) begin
      ev.mode        = sws_pkg::MODE_ACK;
      ev.checksum_ok = 1'b1;
      ev.ack_num     = SEQ_W'((b + s - 1) % s);
    end else if (pick < 80) begin
      ev.mode        = sws_pkg::MODE_TIMEOUT;
      ev.expired_seq = SEQ_W'(b);
    end else begin
      ev.mode = MODE_W'($urandom_range(0, 3));
    end
    if (sb.hits_empty_slot(ev)) ev.mode = sws_pkg::MODE_SEND;
    return ev;
  endfunction

  task automatic drive_event(sws_event_t ev);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= ev.mode;
    in_ch.payload     <= ev.payload;
    in_ch.ack_num     <= ev.ack_num;
    in_ch.checksum_ok <= ev.checksum_ok;
    in_ch.expired_seq <= ev.expired_seq;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(ev);
    @(negedge clk);
  endtask

  task automatic settle(int unsigned tail);
    in_ch.valid <= 1'b0;
    while (sb.pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_cfg(logic [sws_pkg::CFG_IDX_W-1:0] idx,
                           logic [sws_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  initial begin
    int unsigned cfg_plan [NUM_PHASES][2];
    cfg_plan = '{'{4, 8}, '{1, 2}, '{15, 16}, '{0, 0}, '{31, 31}, '{15, 5},
                 '{7, 1}, '{8, 9}, '{2, 16}, '{0, 0}, '{0, 0}};
    sb = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = sws_pkg::MODE_SEND;
    in_ch.payload     = '0;
    in_ch.ack_num     = '0;
    in_ch.checksum_ok = 1'b0;
    in_ch.expired_seq = '0;
    out_ch.ready      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings: window 4, space 8
    drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd0, 1'b0, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_TIMEOUT, 32'h0, 4'd0, 1'b1, 4'd15));
    drive_event(mk_event(MODE_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1, 4'd15));
    // duplicates with nothing in flight only count, up to saturation
    repeat (8) drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd7, 1'b1, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_SEND, 32'h0000_0000, 4'd0, 1'b0, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd7, 1'b1, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_SEND, 32'hFFFF_FFFF, 4'd0, 1'b0, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_SEND, 32'hA5A5_A5A5, 4'd0, 1'b0, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_SEND, 32'h5A5A_5A5A, 4'd0, 1'b0, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_SEND, 32'h1234_5678, 4'd0, 1'b0, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd15, 1'b1, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd5, 1'b1, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd1, 1'b1, 4'd0));
    repeat (3) drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd1, 1'b1, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_TIMEOUT, 32'h0, 4'd0, 1'b0, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_ACK, 32'h0, 4'd3, 1'b1, 4'd0));
    drive_event(mk_event(sws_pkg::MODE_TIMEOUT, 32'h0, 4'd0, 1'b0, 4'd15));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        settle(4);
        if (phase >= 9) begin
          cfg_plan[phase][0] = $urandom_range(0, 31);
          cfg_plan[phase][1] = $urandom_range(0, 31);
        end
        write_cfg(sws_pkg::CFG_WINDOW_SIZE, CFG_DATA_W'(cfg_plan[phase][0]));
        write_cfg(sws_pkg::CFG_SEQ_SPACE, CFG_DATA_W'(cfg_plan[phase][1]));
      end
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      repeat (ITEMS_PER_PHASE) drive_event(random_event());
    end

    settle(10);
    if (sb.pending != 0) $display("%0d results never arrived", sb.pending);
    if (sb.failures == 0 && sb.pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
